// File: src/range_max_tree_core_macros.svh
// assertion macros shared by the range max tree rtl
// no dependencies; included by files that carry concurrent checks
`ifndef RANGE_MAX_TREE_CORE_MACROS_SVH
`define RANGE_MAX_TREE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RMT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RMT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define RMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: src/rmt_pkg.sv
// types and constants of the range max tree
// no dependencies; used by the channel interfaces and the core
package rmt_pkg;

   localparam int IDX_W  = 10;
   localparam int DATA_W = 32;
   localparam int CSR_W  = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_LAST_INDEX = 1'b0;

   localparam logic [IDX_W-1:0]  LAST_INDEX_RESET = 10'd1023;
   localparam logic [DATA_W-1:0] NEG_SENTINEL     = 32'hE000_0000;
   localparam logic [DATA_W-1:0] MOST_NEGATIVE    = 32'h8000_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_UP,
      ST_QRY
   } rmt_state_type;

endpackage

// File: src/rmt_if.sv
// valid/ready channel interfaces for the request and response beats
// depends on rmt_pkg for field widths
interface rmt_req_if import rmt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic        [IDX_W-1:0]  index_low;
   logic        [IDX_W-1:0]  index_high;
   logic signed [DATA_W-1:0] leaf_value;

   modport source (output valid, opcode, index_low, index_high, leaf_value, input ready);
   modport sink   (input valid, opcode, index_low, index_high, leaf_value, output ready);
endinterface

interface rmt_rsp_if import rmt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] max_value;
   logic                     range_error;

   modport source (output valid, max_value, range_error, input ready);
   modport sink   (input valid, max_value, range_error, output ready);
endinterface

// File: src/range_max_tree_core.sv
// Range-maximum segment tree over LEAVES signed 32-bit leaves, kept in one node
// memory of twice LEAVES rounded up to a power of two words, with one write and
// one registered read port; a small sequencer walks the tree.
// A write beat stores the leaf and then rewrites each ancestor up to the root,
// one level per cycle, and gives no response. A query beat walks both range
// ends up the tree; at each level it reads the boundary nodes one at a time
// through the single read port, then steps both ends up. The input is not
// ready while a beat is in the walk; the response sits in an output register
// so the next beat is taken while it waits. Empty or out-of-span queries
// answer -(2^29) with range_error set. Leaves must be written before any
// query covers them. last_index is written over APB at byte address 0.
// depends on rmt_pkg, rmt_if.sv and range_max_tree_core_macros.svh
`include "range_max_tree_core_macros.svh"

module range_max_tree_core import rmt_pkg::*; #(
   parameter int LEAVES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   rmt_req_if.sink          req_bus,
   rmt_rsp_if.source        rsp_bus,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [CSR_W-1:0] csr_pwdata,
   output logic [CSR_W-1:0] csr_prdata,
   output logic             csr_pready
);

   localparam int LEAF_W = $clog2(LEAVES);
   localparam int NODE_W = LEAF_W + 1;
   localparam int PTR_W  = NODE_W + 1;
   localparam int unsigned LastLeaf = LEAVES - 1;
   localparam logic [PTR_W-1:0]  NodeEnd = PTR_W'(1 << NODE_W);
   localparam logic [NODE_W-1:0] RootNode = NODE_W'(1);

   rmt_state_type state_ff, state_in;

   logic [IDX_W-1:0]         last_index_ff, last_index_in;
   logic [NODE_W-1:0]        upd_node_ff, upd_node_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic [PTR_W-1:0]         qry_a_ff, qry_a_in;
   logic [PTR_W-1:0]         qry_b_ff, qry_b_in;
   logic                     pend_ff, pend_in;
   logic                     err_ff, err_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_max_ff, rsp_max_in;
   logic                     rsp_err_ff, rsp_err_in;

   logic signed [DATA_W-1:0] tree_mem [1 << NODE_W];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     mem_we;
   logic [NODE_W-1:0]        mem_waddr;
   logic signed [DATA_W-1:0] mem_wdata;
   logic [NODE_W-1:0]        mem_raddr;

   logic                     req_fire;
   logic                     csr_wr;
   logic [LEAF_W-1:0]        leaf_off;
   logic [LEAF_W-1:0]        hi_off;
   logic                     lo_beyond;
   logic                     hi_beyond;
   logic signed [DATA_W-1:0] fold_max;
   logic signed [DATA_W-1:0] up_max;
   logic [NODE_W-1:0]        parent;
   logic [PTR_W-1:0]         b_dec;
   logic                     rsp_free;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      last_index_in = last_index_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_LAST_INDEX)) begin
         last_index_in = csr_pwdata[IDX_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_LAST_INDEX) begin
         csr_prdata = {{(CSR_W-IDX_W){1'b0}}, last_index_ff};
      end
   end

   // ---------------- node memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= tree_mem[mem_raddr];
   end

   // ---------------- datapath helpers ----------------
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign leaf_off  = LEAF_W'(req_bus.index_low);
   assign hi_off    = LEAF_W'(req_bus.index_high);
   assign lo_beyond = (req_bus.index_low > last_index_ff) ||
                      (32'(req_bus.index_low) > LastLeaf);
   assign hi_beyond = (req_bus.index_high > last_index_ff) ||
                      (32'(req_bus.index_high) > LastLeaf);
   // fold the node read issued last cycle into the running maximum
   assign fold_max  = (pend_ff && (rd_data_ff > acc_ff)) ? rd_data_ff : acc_ff;
   assign up_max    = (rd_data_ff > acc_ff) ? rd_data_ff : acc_ff;
   assign parent    = {1'b0, upd_node_ff[NODE_W-1:1]};
   assign b_dec     = qry_b_ff - PTR_W'(1);
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.max_value   = rsp_max_ff;
   assign rsp_bus.range_error = rsp_err_ff;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_index_ff <= LAST_INDEX_RESET;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         err_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_index_ff <= last_index_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         err_ff        <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_node_ff <= upd_node_in;
      acc_ff      <= acc_in;
      qry_a_ff    <= qry_a_in;
      qry_b_ff    <= qry_b_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_err_ff  <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      upd_node_in  = upd_node_ff;
      acc_in       = acc_ff;
      qry_a_in     = qry_a_ff;
      qry_b_in     = qry_b_ff;
      pend_in      = 1'b0;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_max_in   = rsp_max_ff;
      rsp_err_in   = rsp_err_ff;
      mem_we       = 1'b0;
      mem_waddr    = upd_node_ff;
      mem_wdata    = acc_ff;
      mem_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.opcode == OP_WRITE) begin
                  // writes beyond the span are dropped
                  if (!lo_beyond) begin
                     upd_node_in = {1'b1, leaf_off};
                     acc_in      = req_bus.leaf_value;
                     state_in    = ST_UPD_LEAF;
                  end
               end else begin
                  if ((req_bus.index_low > req_bus.index_high) || hi_beyond) begin
                     // empty walk, answer comes straight from acc
                     qry_a_in = '0;
                     qry_b_in = '0;
                     acc_in   = NEG_SENTINEL;
                     err_in   = 1'b1;
                  end else begin
                     qry_a_in = {2'b01, leaf_off};
                     qry_b_in = {2'b01, hi_off} + PTR_W'(1);
                     acc_in   = MOST_NEGATIVE;
                     err_in   = 1'b0;
                  end
                  state_in = ST_QRY;
               end
            end
         end
         ST_UPD_LEAF: begin
            mem_we    = 1'b1;
            mem_waddr = upd_node_ff;
            mem_wdata = acc_ff;
            mem_raddr = upd_node_ff ^ NODE_W'(1);
            state_in  = ST_UPD_UP;
         end
         ST_UPD_UP: begin
            // rd_data holds the sibling of upd_node
            mem_we      = 1'b1;
            mem_waddr   = parent;
            mem_wdata   = up_max;
            acc_in      = up_max;
            upd_node_in = parent;
            mem_raddr   = parent ^ NODE_W'(1);
            if (parent == RootNode) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY: begin
            acc_in = fold_max;
            if (qry_a_ff < qry_b_ff) begin
               if (qry_a_ff[0]) begin
                  mem_raddr = qry_a_ff[NODE_W-1:0];
                  qry_a_in  = qry_a_ff + PTR_W'(1);
                  pend_in   = 1'b1;
               end else if (qry_b_ff[0]) begin
                  mem_raddr = b_dec[NODE_W-1:0];
                  qry_b_in  = b_dec;
                  pend_in   = 1'b1;
               end else begin
                  qry_a_in = qry_a_ff >> 1;
                  qry_b_in = qry_b_ff >> 1;
               end
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = fold_max;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- checks ----------------
   `RMT_ASSERT_NEXT(a_write_no_beat, clock, reset, req_fire && (req_bus.opcode == OP_WRITE) && !rsp_valid_ff, !rsp_valid_ff, "write beat produced a response")
   `RMT_ASSERT_NOW(a_upd_above_root, clock, reset, state_ff == ST_UPD_UP, upd_node_ff > RootNode, "update walk passed the root")
   `RMT_ASSERT_NOW(a_qry_ptr_range, clock, reset, state_ff == ST_QRY, (qry_b_ff <= NodeEnd) && (qry_a_ff <= NodeEnd), "query pointer out of node range")
   `RMT_ASSERT_NOW(a_err_sentinel, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_max_ff == NEG_SENTINEL, "rejected query without sentinel")

endmodule

// File: test/range_max_tree_core_test.sv
// testbench for range_max_tree_core: directed and random leaf writes and range queries
// checked against a flat-array maximum model; needs rmt_pkg and rmt_if from the rtl
`timescale 1ns / 1ps

module range_max_tree_core_test;
   import rmt_pkg::*;

   localparam int LEAVES      = 1024;
   localparam int SETTLE      = 40;    // longer than the slowest query walk
   localparam int STALL_LIMIT = 3000;  // cycles with no beat before giving up
   localparam int RSP_HOLD    = 400;
   localparam int PHASE_ITEMS = 110;
   localparam logic [2:0] LAST_INDEX_ADDR = {CSR_IDX_LAST_INDEX, 2'b00};

   typedef struct {
      logic                     opcode;
      logic        [IDX_W-1:0]  index_low;
      logic        [IDX_W-1:0]  index_high;
      logic signed [DATA_W-1:0] leaf_value;
   } tree_op_type;

   typedef struct {
      logic signed [DATA_W-1:0] max_value;
      logic                     range_error;
   } range_result_type;

   class max_tree_book_type;
      logic signed [DATA_W-1:0] leaf_store [LEAVES];
      logic [IDX_W-1:0]         span_last;
      range_result_type         awaited [$];
      int fails;
      int stored;
      int ignored;
      int answered;
      int rejected;

      function new();
         span_last = LAST_INDEX_RESET;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(tree_op_type op);
         int top;
         range_result_type r;
         logic signed [DATA_W-1:0] best;
         top = (int'(span_last) < LEAVES - 1) ? int'(span_last) : LEAVES - 1;
         if (op.opcode == OP_WRITE) begin
            if (int'(op.index_low) <= top) begin
               leaf_store[op.index_low] = op.leaf_value;
               stored++;
            end else begin
               ignored++;
            end
         end else if (op.index_low > op.index_high || int'(op.index_high) > top) begin
            r.max_value   = NEG_SENTINEL;
            r.range_error = 1'b1;
            awaited = {awaited, r};
            rejected++;
         end else begin
            best = leaf_store[op.index_low];
            for (int i = int'(op.index_low) + 1; i <= int'(op.index_high); i++)
               if (leaf_store[i] > best) best = leaf_store[i];
            r.max_value   = best;
            r.range_error = 1'b0;
            awaited = {awaited, r};
            answered++;
         end
      endfunction

      function void check_result(logic signed [DATA_W-1:0] max_value, logic range_error);
         range_result_type r;
         if (awaited.size() == 0) begin
            $error("response beat with no query waiting: max_value %0d range_error %0b",
                   max_value, range_error);
            fails++;
            return;
         end
         r = awaited.pop_front();
         if (max_value !== r.max_value) begin
            $error("max_value: expected %0d, got %0d", r.max_value, max_value);
            fails++;
         end
         if (range_error !== r.range_error) begin
            $error("range_error: expected %0b, got %0b", r.range_error, range_error);
            fails++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [2:0]       csr_paddr;
   logic [CSR_W-1:0] csr_pwdata;
   logic [CSR_W-1:0] csr_prdata;
   logic             csr_pready;

   rmt_req_if req_bus ();
   rmt_rsp_if rsp_bus ();

   max_tree_book_type book = new();
   bit           steady;
   int           csr_fails;
   int           span_count;

   range_max_tree_core #(.LEAVES(LEAVES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic tree_op_type make_op(logic opcode, int lo, int hi, logic [DATA_W-1:0] value);
      tree_op_type op;
      op.opcode     = opcode;
      op.index_low  = lo[IDX_W-1:0];
      op.index_high = hi[IDX_W-1:0];
      op.leaf_value = value;
      return op;
   endfunction

   function automatic logic [DATA_W-1:0] random_value();
      int pick;
      pick = $urandom_range(4);
      if (pick == 0) begin
         case ($urandom_range(6))
            0:       return MOST_NEGATIVE;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return NEG_SENTINEL;
            5:       return NEG_SENTINEL - 1;
            default: return NEG_SENTINEL + 1;
         endcase
      end else if (pick <= 2) begin
         return $urandom;
      end
      // narrow band so that single writes move the maxima
      return int'($urandom_range(200)) - 100;
   endfunction

   function automatic tree_op_type random_op(int top);
      int roll;
      int lo;
      int hi;
      roll = $urandom_range(99);
      if (roll < 45) begin
         lo = ($urandom_range(99) < 85) ? $urandom_range(top, 0) : $urandom_range(LEAVES - 1, 0);
         return make_op(OP_WRITE, lo, $urandom, random_value());
      end
      roll = $urandom_range(99);
      if (roll < 12) begin
         lo = $urandom_range(LEAVES - 1, 1);
         hi = $urandom_range(lo - 1, 0);
      end else if (roll < 20 && top < LEAVES - 1) begin
         hi = $urandom_range(LEAVES - 1, top + 1);
         lo = $urandom_range(hi, 0);
      end else if (roll < 60) begin
         lo = $urandom_range(top, 0);
         hi = lo + $urandom_range(15, 0);
         if (hi > top) hi = top;
      end else begin
         lo = $urandom_range(top, 0);
         hi = $urandom_range(top, lo);
      end
      return make_op(OP_QUERY, lo, hi, $urandom);
   endfunction

   task automatic send_beat(input tree_op_type op);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 17) gap = $urandom_range(6, 1);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op.opcode;
      req_bus.index_low  <= op.index_low;
      req_bus.index_high <= op.index_high;
      req_bus.leaf_value <= op.leaf_value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.note_request(op);
   endtask

   // stop offering and let every outstanding query come back
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_check(input logic [IDX_W-1:0] want);
      logic [CSR_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= LAST_INDEX_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got[IDX_W-1:0] !== want) begin
         $error("last_index: expected %0d, got %0d", want, got[IDX_W-1:0]);
         csr_fails++;
      end
   endtask

   task automatic set_span(input int last);
      quiesce();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LAST_INDEX_ADDR;
      csr_pwdata  <= last;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      book.span_last = last[IDX_W-1:0];
      span_count++;
      @(posedge clock);
      csr_check(last[IDX_W-1:0]);
   endtask

   // response side: random back-pressure plus one long hold to fill the block
   initial begin : rsp_side
      int taken;
      int hold;
      taken = 0;
      hold  = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            book.check_result(rsp_bus.max_value, rsp_bus.range_error);
            taken++;
            if (taken == 30) hold = RSP_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 17);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $error("no beat for %0d cycles, %0d queries outstanding", STALL_LIMIT, book.pending());
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int span;
      reset              <= 1'b1;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_WRITE;
      req_bus.index_low  <= '0;
      req_bus.index_high <= '0;
      req_bus.leaf_value <= '0;
      steady     = 1'b0;
      csr_fails  = 0;
      span_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(LAST_INDEX_RESET);

      // extremes of the value range at the ends and middle of the tree
      send_beat(make_op(OP_WRITE, 0, 0, MOST_NEGATIVE));
      send_beat(make_op(OP_WRITE, 1, 1023, 32'h7FFF_FFFF));
      send_beat(make_op(OP_WRITE, 2, 0, 32'hFFFF_FFFF));
      send_beat(make_op(OP_WRITE, 3, 0, 32'h0000_0000));
      send_beat(make_op(OP_WRITE, 1023, 0, NEG_SENTINEL));
      send_beat(make_op(OP_WRITE, 1022, 0, NEG_SENTINEL - 1));
      send_beat(make_op(OP_WRITE, 512, 0, 32'd5));
      send_beat(make_op(OP_WRITE, 511, 0, -32'sd5));
      send_beat(make_op(OP_QUERY, 0, 0, 0));
      send_beat(make_op(OP_QUERY, 0, 3, 0));
      send_beat(make_op(OP_QUERY, 2, 3, 0));
      send_beat(make_op(OP_QUERY, 1023, 1023, 0));
      send_beat(make_op(OP_QUERY, 1022, 1023, 0));
      send_beat(make_op(OP_QUERY, 511, 512, 0));
      // empty ranges
      send_beat(make_op(OP_QUERY, 3, 2, 0));
      send_beat(make_op(OP_QUERY, 1023, 0, 0));
      // overwrite the maximum
      send_beat(make_op(OP_WRITE, 1, 0, -32'sd7));
      send_beat(make_op(OP_QUERY, 0, 3, 0));

      // one-leaf span: writes past it are dropped, queries past it rejected
      set_span(0);
      send_beat(make_op(OP_WRITE, 0, 0, 32'd42));
      send_beat(make_op(OP_WRITE, 3, 0, 32'd99));
      send_beat(make_op(OP_QUERY, 0, 0, 0));
      send_beat(make_op(OP_QUERY, 0, 1, 0));
      send_beat(make_op(OP_QUERY, 1023, 1023, 0));
      // leaf values survive the span change
      set_span(LEAVES - 1);
      send_beat(make_op(OP_QUERY, 2, 3, 0));

      // every leaf gets a value before random ranges can land on it
      steady = 1'b1;
      for (int i = 0; i < LEAVES; i++)
         send_beat(make_op(OP_WRITE, i, $urandom, random_value()));
      steady = 1'b0;

      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       span = LEAVES - 1;
            1:       span = $urandom_range(LEAVES - 2, 2);
            2:       span = 1;
            3:       span = 0;
            default: span = LEAVES - 1;
         endcase
         set_span(span);
         steady = (p == 4);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 0 && k == PHASE_ITEMS / 2) quiesce();
            send_beat(random_op(span));
         end
      end
      steady = 1'b0;
      quiesce();

      $display("%0d leaf writes stored, %0d dropped outside the span", book.stored, book.ignored);
      $display("%0d range maxima and %0d rejected ranges checked over %0d span settings",
               book.answered, book.rejected, span_count);
      if (book.pending() != 0)
         $error("%0d queries never answered", book.pending());
      if (book.fails == 0 && csr_fails == 0 && book.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/rmt_pkg.sv
src/rmt_if.sv
src/range_max_tree_core.sv
test/range_max_tree_core_test.sv
